// ===== design/mgwp_pkg.sv =====
// ----------------------------------------------------------------------------
// mgwp_pkg
// Shared widths, reset values, register indexes and chain types for the
// minimum gap weighted placement core.
// ----------------------------------------------------------------------------
package mgwp_pkg;

  localparam int POS_W     = 11;
  localparam int REV_W     = 16;
  localparam int TOTAL_W   = 26;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam int MGWP_MAX_MILES = 1024;

  // table is interleaved over the cells by the low mile bits
  localparam int CELL_SEL_W = 2;
  localparam int CELL_COUNT = 2 ** CELL_SEL_W;

  localparam logic [CFG_W-1:0] MIN_GAP_RESET     = CFG_W'(5);
  localparam logic [CFG_W-1:0] ROAD_LENGTH_RESET = CFG_W'(20);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_LENGTH = 1'b1;

  typedef struct packed {
    logic valid;
    logic wr;
  } mgwp_op_t;

  typedef struct packed {
    logic               valid;
    logic [TOTAL_W-1:0] data;
  } mgwp_resp_t;

endpackage

// ===== design/min_gap_weighted_placement_core.sv =====
// ----------------------------------------------------------------------------
// min_gap_weighted_placement_core
// Streaming best-revenue placement: per-mile best totals kept in a chain of
// table cells, site requests sequenced by a small controller.
// ----------------------------------------------------------------------------
// Sequencing: a site holds busy while its earlier miles are filled (one mile
// filled per cycle), the look-back mile is read over the 4-cell chain unless
// it is mile zero, and the site is written. A last item fills the remaining
// miles, then answers from the running best or from a table read.
// Throughput: one item at a time; busy stays high until the item is done.
// Reset clears list state and sets min_gap 5, road_length 20; table contents
// stay undefined (no clearing pass). done pulses one cycle, no stall.
// ----------------------------------------------------------------------------
module min_gap_weighted_placement_core
  import mgwp_pkg::*;
#(
  parameter int MAX_MILES = MGWP_MAX_MILES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [POS_W-1:0]     position,
  input  logic [REV_W-1:0]     revenue,
  input  logic                 present,
  input  logic                 last,
  output logic                 done,
  output logic [TOTAL_W-1:0]   max_total,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int MW = $clog2(MAX_MILES + 1);
  localparam int XW = (MW > POS_W) ? MW : POS_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CARRY     = 3'd1;
  localparam logic [2:0] S_LOOK      = 3'd2;
  localparam logic [2:0] S_LOOK_WAIT = 3'd3;
  localparam logic [2:0] S_PLACE     = 3'd4;
  localparam logic [2:0] S_ANSWER    = 3'd5;
  localparam logic [2:0] S_ANS_WAIT  = 3'd6;

  logic [2:0]         state;
  logic [CFG_W-1:0]   min_gap;
  logic [CFG_W-1:0]   road_length;
  logic [MW-1:0]      filled;
  logic [TOTAL_W-1:0] run_best;
  logic               stalled;
  logic [MW-1:0]      site_mile;
  logic [REV_W-1:0]   site_rev;
  logic               item_last;
  logic               to_site;
  logic [MW-1:0]      target;
  logic [TOTAL_W-1:0] look_val;
  mgwp_op_t           req_op;
  logic [MW-1:0]      req_addr;
  logic [TOTAL_W-1:0] req_data;

  mgwp_op_t           op_c   [CELL_COUNT+1];
  logic [MW-1:0]      addr_c [CELL_COUNT+1];
  logic [TOTAL_W-1:0] data_c [CELL_COUNT+1];
  mgwp_resp_t         resp_c [CELL_COUNT+1];
  mgwp_resp_t         resp_end;

  logic [XW-1:0]      max_x;
  logic [XW-1:0]      road_x;
  logic [XW-1:0]      len_x;
  logic [MW-1:0]      len;
  logic [XW-1:0]      pos_x;
  logic               pos_ok;
  logic               site_ok;
  logic [XW:0]        site_g;
  logic [XW:0]        gap_p1;
  logic               near;
  logic [XW:0]        look_g;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] take;
  logic [TOTAL_W-1:0] new_best;

  // ---- table chain
  assign op_c[0]   = req_op;
  assign addr_c[0] = req_addr;
  assign data_c[0] = req_data;
  assign resp_c[0] = '0;
  assign resp_end  = resp_c[CELL_COUNT];

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    mgwp_cell #(
      .ADDR_W   (MW),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op_in    (op_c[i]),
      .addr_in  (addr_c[i]),
      .data_in  (data_c[i]),
      .resp_in  (resp_c[i]),
      .op_out   (op_c[i+1]),
      .addr_out (addr_c[i+1]),
      .data_out (data_c[i+1]),
      .resp_out (resp_c[i+1])
    );
  end

  // ---- datapath
  assign max_x   = XW'(MAX_MILES);
  assign road_x  = XW'(road_length);
  assign len_x   = (road_x > max_x) ? max_x : road_x;
  assign len     = len_x[MW-1:0];
  assign pos_x   = XW'(position);
  assign pos_ok  = (pos_x > XW'(filled)) && (pos_x <= len_x);
  assign site_ok = present && !stalled && pos_ok;

  assign site_g = (XW+1)'(site_mile);
  assign gap_p1 = (XW+1)'(min_gap) + (XW+1)'(1);
  assign near   = site_g <= gap_p1;
  assign look_g = site_g - gap_p1;

  assign sum      = {1'b0, look_val} + (TOTAL_W+1)'(site_rev);
  assign take     = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign new_best = (take > run_best) ? take : run_best;

  assign busy = (state != S_IDLE);

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap     <= MIN_GAP_RESET;
      road_length <= ROAD_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_GAP:     min_gap     <= cfg_data;
        REG_ROAD_LENGTH: road_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      filled   <= '0;
      run_best <= '0;
      stalled  <= 1'b0;
      req_op   <= '0;
      done     <= 1'b0;
    end else begin
      req_op <= '0;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_last <= last;
            site_mile <= pos_x[MW-1:0];
            site_rev  <= revenue;
            if (present && !stalled && !pos_ok) begin
              stalled <= 1'b1;
            end
            if (site_ok) begin
              target  <= pos_x[MW-1:0] - MW'(1);
              to_site <= 1'b1;
              state   <= S_CARRY;
            end else if (last) begin
              target  <= len;
              to_site <= 1'b0;
              state   <= S_CARRY;
            end
          end
        end
        S_CARRY: begin
          if (filled < target) begin
            req_op   <= '{valid: 1'b1, wr: 1'b1};
            req_addr <= filled + MW'(1);
            req_data <= run_best;
            filled   <= filled + MW'(1);
          end else begin
            state <= to_site ? S_LOOK : S_ANSWER;
          end
        end
        S_LOOK: begin
          // mile zero is always zero and never stored
          if (near) begin
            look_val <= '0;
            state    <= S_PLACE;
          end else begin
            req_op   <= '{valid: 1'b1, wr: 1'b0};
            req_addr <= look_g[MW-1:0];
            state    <= S_LOOK_WAIT;
          end
        end
        S_LOOK_WAIT: begin
          if (resp_end.valid) begin
            look_val <= resp_end.data;
            state    <= S_PLACE;
          end
        end
        S_PLACE: begin
          req_op   <= '{valid: 1'b1, wr: 1'b1};
          req_addr <= site_mile;
          req_data <= new_best;
          run_best <= new_best;
          filled   <= site_mile;
          if (item_last) begin
            target  <= len;
            to_site <= 1'b0;
            state   <= S_CARRY;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ANSWER: begin
          if (len == filled) begin
            max_total <= run_best;
            done      <= 1'b1;
            filled    <= '0;
            run_best  <= '0;
            stalled   <= 1'b0;
            state     <= S_IDLE;
          end else if (len == '0) begin
            max_total <= '0;
            done      <= 1'b1;
            filled    <= '0;
            run_best  <= '0;
            stalled   <= 1'b0;
            state     <= S_IDLE;
          end else begin
            // road shortened below the filled miles
            req_op   <= '{valid: 1'b1, wr: 1'b0};
            req_addr <= len;
            state    <= S_ANS_WAIT;
          end
        end
        S_ANS_WAIT: begin
          if (resp_end.valid) begin
            max_total <= resp_end.data;
            done      <= 1'b1;
            filled    <= '0;
            run_best  <= '0;
            stalled   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/mgwp_ram.sv =====
// ----------------------------------------------------------------------------
// mgwp_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mgwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/mgwp_cell.sv =====
// ----------------------------------------------------------------------------
// mgwp_cell
// One cell of the table chain: owns the miles whose low bits match its index,
// services requests addressed to it and passes requests and read data on.
// ----------------------------------------------------------------------------
module mgwp_cell
  import mgwp_pkg::*;
#(
  parameter int ADDR_W   = 11,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  mgwp_op_t           op_in,
  input  logic [ADDR_W-1:0]  addr_in,
  input  logic [TOTAL_W-1:0] data_in,
  input  mgwp_resp_t         resp_in,
  output mgwp_op_t           op_out,
  output logic [ADDR_W-1:0]  addr_out,
  output logic [TOTAL_W-1:0] data_out,
  output mgwp_resp_t         resp_out
);

  localparam int LAW = (ADDR_W > CELL_SEL_W) ? ADDR_W - CELL_SEL_W : 1;

  logic               hit;
  logic [ADDR_W-1:0]  addr_shift;
  logic [LAW-1:0]     local_addr;
  logic [TOTAL_W-1:0] ram_q;
  logic               rd_pend;

  assign hit        = op_in.valid &&
                      (addr_in[CELL_SEL_W-1:0] == CELL_SEL_W'(CELL_IDX));
  assign addr_shift = addr_in >> CELL_SEL_W;
  assign local_addr = addr_shift[LAW-1:0];

  mgwp_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (2 ** LAW)
  ) u_ram (
    .clk   (clk),
    .we    (hit && op_in.wr),
    .addr  (local_addr),
    .wdata (data_in),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_out   <= '0;
      rd_pend  <= 1'b0;
      resp_out <= '0;
    end else begin
      op_out  <= op_in;
      rd_pend <= hit && !op_in.wr;
      // read data joins the response stream in the cycle after op_out carries its request
      if (rd_pend) begin
        resp_out <= '{valid: 1'b1, data: ram_q};
      end else begin
        resp_out <= resp_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_out <= addr_in;
    data_out <= data_in;
  end

endmodule

// ===== design/mgwp_checker.sv =====
// ----------------------------------------------------------------------------
// mgwp_checker
// Port-level checks on request acceptance and result strobes of the core.
// ----------------------------------------------------------------------------
module mgwp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic done
);

  // a result leaves the core idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last request did not start work");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !done)
    else $error("result right after a non-last request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("core not quiet after reset");

endmodule

bind min_gap_weighted_placement_core mgwp_checker u_mgwp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .last  (last),
  .done  (done)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks min_gap_weighted_placement_core against a per-mile best-total
// predictor. A directed table covers empty lists, the field extremes, the
// gap boundary and rejected sites. Random phases then reprogram min_gap and
// road_length, including zero, the table size and beyond, and stream site
// lists: mostly increasing well-formed lists, plus broken lists and noise.
// Requests use random idle gaps. Every done strobe is checked against the
// oldest expected total.
// ----------------------------------------------------------------------------
module testbench;
  import mgwp_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int LIMIT_CYCLES = 5000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_N        = 21;
  localparam int FIXED_N      = 11;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [REV_W-1:0]   rev;
    logic               site;
    logic               final_item;
    logic               typed;
    logic [TOTAL_W-1:0] total;
  } site_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [POS_W-1:0]     position;
  logic [REV_W-1:0]     revenue;
  logic                 present;
  logic                 last;
  logic                 done;
  logic [TOTAL_W-1:0]   max_total;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  logic [TOTAL_W-1:0] mile_best [0:MGWP_MAX_MILES];
  int unsigned        reached_mile;
  bit                 list_halted;
  int unsigned        gap_miles;
  int unsigned        road_miles;

  logic [TOTAL_W-1:0] pending_totals [$];
  logic [TOTAL_W-1:0] want_total;
  site_row_t          dir_tab [DIR_N];
  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 cycles = 0;
  bit                 quiet_phase = 1'b0;

  min_gap_weighted_placement_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .position  (position),
    .revenue   (revenue),
    .present   (present),
    .last      (last),
    .done      (done),
    .max_total (max_total),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic score_request(input logic [POS_W-1:0] pos, input logic [REV_W-1:0] rev,
                               input logic site, input logic final_item,
                               output bit has_total, output logic [TOTAL_W-1:0] total);
    int unsigned len_eff;
    int unsigned take;
    int unsigned keep;
    len_eff = (road_miles > MGWP_MAX_MILES) ? MGWP_MAX_MILES : road_miles;
    has_total = 1'b0;
    total = '0;
    if (site && !list_halted) begin
      if (pos > reached_mile && pos <= len_eff) begin
        while (reached_mile + 1 < pos) begin
          reached_mile++;
          mile_best[reached_mile] = mile_best[reached_mile - 1];
        end
        keep = mile_best[pos - 1];
        if (pos <= gap_miles) take = rev;
        else take = mile_best[pos - gap_miles - 1] + rev;
        if (take > TOTAL_MAX) take = TOTAL_MAX;
        mile_best[pos] = TOTAL_W'((take > keep) ? take : keep);
        reached_mile = pos;
      end else begin
        list_halted = 1'b1;
      end
    end
    if (final_item) begin
      while (reached_mile < len_eff) begin
        reached_mile++;
        mile_best[reached_mile] = mile_best[reached_mile - 1];
      end
      total = mile_best[len_eff];
      has_total = 1'b1;
      reached_mile = 0;
      list_halted = 1'b0;
      mile_best[0] = '0;
    end
  endtask

  function automatic int pick_idle();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [REV_W-1:0] pick_revenue();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return REV_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_req(input logic [POS_W-1:0] pos, input logic [REV_W-1:0] rev,
                          input logic site, input logic final_item,
                          input logic typed, input logic [TOTAL_W-1:0] typed_total);
    int                 idle;
    bit                 has_total;
    logic [TOTAL_W-1:0] total;
    idle = pick_idle();
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start    <= 1'b1;
    position <= pos;
    revenue  <= rev;
    present  <= site;
    last     <= final_item;
    @(posedge clk);
    while (busy) @(posedge clk);
    score_request(pos, rev, site, final_item, has_total, total);
    if (has_total) pending_totals.push_back(typed ? typed_total : total);
    items_sent++;
  endtask

  task automatic send_noise(input logic final_item);
    send_req(POS_W'($urandom_range(0, 2047)), pick_revenue(), 1'($urandom_range(0, 1)),
             final_item, 1'b0, '0);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_totals.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_MIN_GAP) gap_miles = val;
    else road_miles = val;
  endtask

  task automatic configure(input int unsigned gap, input int unsigned len);
    settle();
    write_reg(REG_MIN_GAP, CFG_W'(gap));
    write_reg(REG_ROAD_LENGTH, CFG_W'(len));
    cfg_write <= 1'b0;
  endtask

  task automatic send_list();
    int unsigned len_eff;
    int unsigned prev;
    int unsigned k;
    int unsigned cnt;
    int unsigned step_max;
    int unsigned p;
    int unsigned mode;
    len_eff = (road_miles > MGWP_MAX_MILES) ? MGWP_MAX_MILES : road_miles;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      send_noise(1'b1);
      return;
    end
    if (mode == 8) begin
      repeat ($urandom_range(1, 8)) send_noise(1'b0);
      send_noise(1'b1);
      return;
    end
    k = $urandom_range(1, (len_eff > 200) ? 60 : 12);
    step_max = (len_eff * 2) / k + 1;
    prev = 0;
    cnt = 0;
    while (cnt < k && len_eff > prev) begin
      if (mode == 7 && cnt == k / 2) begin
        // rejected site: repeat/backward or off the road
        if ($urandom_range(0, 1)) send_req(POS_W'($urandom_range(0, prev)), pick_revenue(),
                                           1'b1, 1'b0, 1'b0, '0);
        else send_req(POS_W'($urandom_range(len_eff + 1, 2047)), pick_revenue(),
                      1'b1, 1'b0, 1'b0, '0);
      end
      if ($urandom_range(0, 5) == 0)
        send_req(POS_W'($urandom_range(0, 2047)), pick_revenue(), 1'b0, 1'b0, 1'b0, '0);
      p = prev + $urandom_range(1, step_max);
      if (p > len_eff) p = len_eff;
      send_req(POS_W'(p), pick_revenue(), 1'b1, 1'b0, 1'b0, '0);
      prev = p;
      cnt++;
    end
    if ($urandom_range(0, 1) && len_eff > prev)
      send_req(POS_W'(($urandom_range(0, 1)) ? len_eff : $urandom_range(prev + 1, len_eff)),
               pick_revenue(), 1'b1, 1'b1, 1'b0, '0);
    else
      send_req(POS_W'($urandom_range(0, 2047)), pick_revenue(), 1'b0, 1'b1, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected result max_total=%0d", max_total));
      end else begin
        want_total = pending_totals.pop_front();
        if (max_total !== want_total)
          report_mismatch($sformatf("max_total expected %0d got %0d", want_total, max_total));
      end
    end
  end

  initial begin
    int          fx_gap [FIXED_N];
    int          fx_len [FIXED_N];
    int          fx_lists [FIXED_N];
    int          ph;
    int unsigned gap;
    int unsigned len;
    int          lists;
    fx_gap   = '{0, 0, 1, 2047, 3, 1024, 7, 0, 2, 1023, 4};
    fx_len   = '{1, 30, 16, 40, 2047, 1024, 64, 0, 100, 1000, 25};
    fx_lists = '{4, 6, 6, 5, 1, 1, 8, 3, 6, 1, 8};
    // pos, revenue, present, last, typed, expected total (default gap 5, length 20)
    dir_tab = '{
      '{11'd0,    16'd0,     1'b0, 1'b1, 1'b1, 26'd0},
      '{11'd1,    16'hFFFF,  1'b1, 1'b1, 1'b1, 26'd65535},
      '{11'd20,   16'd100,   1'b1, 1'b1, 1'b1, 26'd100},
      '{11'd0,    16'd50,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd3,    16'd70,    1'b1, 1'b1, 1'b1, 26'd0},
      '{11'd21,   16'd9,     1'b1, 1'b1, 1'b1, 26'd0},
      '{11'h7FF,  16'hFFFF,  1'b1, 1'b1, 1'b1, 26'd0},
      '{11'd1,    16'd10,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd6,    16'd20,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd7,    16'd15,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd7,    16'd500,   1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd20,   16'd1000,  1'b1, 1'b1, 1'b0, 26'd0},
      '{11'd5,    16'd30,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd11,   16'd40,    1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd12,   16'd0,     1'b0, 1'b0, 1'b0, 26'd0},
      '{11'd12,   16'd5,     1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd0,    16'd0,     1'b0, 1'b1, 1'b0, 26'd0},
      '{11'd20,   16'hFFFF,  1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd0,    16'd0,     1'b0, 1'b1, 1'b1, 26'd65535},
      '{11'd1,    16'hFFFF,  1'b1, 1'b0, 1'b0, 26'd0},
      '{11'd20,   16'hFFFF,  1'b1, 1'b1, 1'b1, 26'd131070}
    };
    mile_best[0] = '0;
    reached_mile = 0;
    list_halted  = 1'b0;
    gap_miles    = MIN_GAP_RESET;
    road_miles   = ROAD_LENGTH_RESET;

    rst       <= 1'b1;
    start     <= 1'b0;
    position  <= '0;
    revenue   <= '0;
    present   <= 1'b0;
    last      <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_req(dir_tab[i].pos, dir_tab[i].rev, dir_tab[i].site, dir_tab[i].final_item,
               dir_tab[i].typed, dir_tab[i].total);

    ph = 0;
    while (ph < FIXED_N || items_sent < DIR_N + RANDOM_ITEMS) begin
      if (ph < FIXED_N) begin
        gap   = fx_gap[ph];
        len   = fx_len[ph];
        lists = fx_lists[ph];
      end else begin
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 2047);
        case ($urandom_range(0, 9))
          8:       len = 0;
          9:       len = $urandom_range(200, 2047);
          default: len = $urandom_range(1, 120);
        endcase
        lists = (len > 200) ? 2 : $urandom_range(3, 8);
      end
      configure(gap, len);
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (lists) send_list();
      ph++;
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mgwp_pkg.sv
design/mgwp_ram.sv
design/mgwp_cell.sv
design/min_gap_weighted_placement_core.sv
design/mgwp_checker.sv
test/testbench.sv
